/* rtl/sfcs_pkg.sv */
// Types, command codes and frame-building functions for the SPI flash command sequencer.
`timescale 1ns / 1ps
`default_nettype none

package sfcs_pkg;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PRELUDE,
      PH_MAIN,
      PH_POLL
   } phase_type;

   typedef struct packed {
      logic [3:0]  op;
      logic [23:0] address;
      logic [15:0] length;
      logic        protect;
      logic        want_wait;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  opcode;
      logic [23:0] frame_address;
      logic        has_address;
      logic [7:0]  extra_byte;
      logic        has_extra_byte;
      logic [7:0]  tx_data_len;
      logic [16:0] rx_len;
      logic [7:0]  done_one;
      logic [7:0]  done_two;
      logic [7:0]  done_three;
      logic        last;
   } rsp_type;

   localparam logic [3:0] OP_ID      = 4'd0;
   localparam logic [3:0] OP_STATUS  = 4'd1;
   localparam logic [3:0] OP_READ    = 4'd2;
   localparam logic [3:0] OP_PROGRAM = 4'd3;
   localparam logic [3:0] OP_SECTOR  = 4'd4;
   localparam logic [3:0] OP_BLK32   = 4'd5;
   localparam logic [3:0] OP_BLK64   = 4'd6;
   localparam logic [3:0] OP_CHIP    = 4'd7;
   localparam logic [3:0] OP_PROTECT = 4'd8;

   localparam logic [1:0] KIND_FRAME  = 2'd0;
   localparam logic [1:0] KIND_DONE   = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   localparam logic [7:0] CMD_WRITE_STATUS  = 8'h01;
   localparam logic [7:0] CMD_PROGRAM       = 8'h02;
   localparam logic [7:0] CMD_READ          = 8'h03;
   localparam logic [7:0] CMD_READ_STATUS   = 8'h05;
   localparam logic [7:0] CMD_WRITE_ENABLE  = 8'h06;
   localparam logic [7:0] CMD_SECTOR_ERASE  = 8'h20;
   localparam logic [7:0] CMD_EWSR          = 8'h50;
   localparam logic [7:0] CMD_BLK32_ERASE   = 8'h52;
   localparam logic [7:0] CMD_BLK64_ERASE   = 8'hD8;
   localparam logic [7:0] CMD_CHIP_ERASE    = 8'hC7;
   localparam logic [7:0] CMD_READ_ID       = 8'h9F;
   localparam logic [7:0] PROTECT_ALL       = 8'h3C;
   localparam logic [7:0] PROTECT_NONE      = 8'h00;

   localparam logic [16:0] RX_ID     = 17'd4;
   localparam logic [16:0] RX_STATUS = 17'd2;
   localparam logic [16:0] RX_READ_HDR = 17'd4;

   // Result items waiting for the consumer.
   localparam int OUT_DEPTH = 3;

   function automatic logic [7:0] prelude_of(input logic [3:0] op);
      logic [7:0] code;
      code = 8'h00;
      if (op inside {[OP_PROGRAM:OP_CHIP]}) begin
         code = CMD_WRITE_ENABLE;
      end else if (op == OP_PROTECT) begin
         code = CMD_EWSR;
      end
      return code;
   endfunction

   function automatic logic waits(input req_type r);
      logic w;
      w = 1'b0;
      if (r.op inside {[OP_PROGRAM:OP_BLK64]}) begin
         w = r.want_wait;
      end else if (r.op == OP_CHIP) begin
         w = 1'b1;
      end
      return w;
   endfunction

   function automatic rsp_type main_frame(input req_type r);
      rsp_type v;
      v = '0;
      v.kind = KIND_FRAME;
      case (r.op)
         OP_ID: begin
            v.opcode      = CMD_READ_ID;
            v.has_address = 1'b1;
            v.rx_len      = RX_ID;
         end
         OP_STATUS: begin
            v.opcode = CMD_READ_STATUS;
            v.rx_len = RX_STATUS;
         end
         OP_READ: begin
            v.opcode        = CMD_READ;
            v.frame_address = r.address;
            v.has_address   = 1'b1;
            v.rx_len        = RX_READ_HDR + 17'(r.length);
         end
         OP_PROGRAM: begin
            v.opcode        = CMD_PROGRAM;
            v.frame_address = r.address;
            v.has_address   = 1'b1;
            v.tx_data_len   = r.length[7:0];
         end
         OP_SECTOR: begin
            v.opcode        = CMD_SECTOR_ERASE;
            v.frame_address = r.address;
            v.has_address   = 1'b1;
         end
         OP_BLK32: begin
            v.opcode        = CMD_BLK32_ERASE;
            v.frame_address = r.address;
            v.has_address   = 1'b1;
         end
         OP_BLK64: begin
            v.opcode        = CMD_BLK64_ERASE;
            v.frame_address = r.address;
            v.has_address   = 1'b1;
         end
         OP_CHIP: begin
            v.opcode = CMD_CHIP_ERASE;
         end
         OP_PROTECT: begin
            v.opcode         = CMD_WRITE_STATUS;
            v.extra_byte     = r.protect ? PROTECT_ALL : PROTECT_NONE;
            v.has_extra_byte = 1'b1;
         end
         default: begin
            v.opcode = CMD_READ_ID;
         end
      endcase
      return v;
   endfunction

   // First frame of a request that has just reached the head of the queue.
   function automatic rsp_type start_frame(input req_type r);
      rsp_type v;
      logic [7:0] pre;
      pre = prelude_of(r.op);
      if (pre != 8'h00) begin
         v = '0;
         v.kind = KIND_FRAME;
         v.opcode = pre;
      end else begin
         v = main_frame(r);
      end
      v.last = 1'b1;
      return v;
   endfunction

   function automatic phase_type start_phase(input logic [3:0] op);
      return (prelude_of(op) != 8'h00) ? PH_PRELUDE : PH_MAIN;
   endfunction

endpackage

`default_nettype wire

/* rtl/spi_flash_command_sequencer.sv */
// Top level of the SPI flash command sequencer: request queue, phase control and result queue.
//
//   Channel  Ports    Direction  Carries
//   req      req_*    in         new request (func 0) or frame-finished event (func 1)
//   rsp      rsp_*    out        frame to issue, request completion or rejection
//
// Each input item is decided in the cycle it is accepted; its result items, if any (at most two),
// enter a three-entry registered output queue.
// One item is accepted per cycle while at most one result waits in the output queue;
// the sustained rate is one item per cycle if each item yields one result and no result stalls.
// Reset empties the request queue and the output queue and returns the phase to idle.
// A stalled consumer fills the output queue; req_ready drops until at most one result waits.
`timescale 1ns / 1ps
`default_nettype none

module spi_flash_command_sequencer
   import sfcs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_func,
   input  wire logic [3:0]  req_op,
   input  wire logic [23:0] req_address,
   input  wire logic [15:0] req_length,
   input  wire logic        req_protect,
   input  wire logic        req_want_wait,
   input  wire logic [7:0]  req_reply_one,
   input  wire logic [7:0]  req_reply_two,
   input  wire logic [7:0]  req_reply_three,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_opcode,
   output logic [23:0]      rsp_frame_address,
   output logic             rsp_has_address,
   output logic [7:0]       rsp_extra_byte,
   output logic             rsp_has_extra_byte,
   output logic [7:0]       rsp_tx_data_len,
   output logic [16:0]      rsp_rx_len,
   output logic [7:0]       rsp_done_one,
   output logic [7:0]       rsp_done_two,
   output logic [7:0]       rsp_done_three,
   output logic             rsp_last
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int OUT_CW = $clog2(OUT_DEPTH + 1);

   req_type            q_ff [QUEUE_DEPTH];
   req_type            q_in [QUEUE_DEPTH];
   logic [CNT_W-1:0]   fifo_cnt_ff;
   logic [CNT_W-1:0]   fifo_cnt_in;
   phase_type          phase_ff;
   phase_type          phase_in;
   rsp_type            out_ff [OUT_DEPTH];
   rsp_type            out_in [OUT_DEPTH];
   logic [OUT_CW-1:0]  out_cnt_ff;
   logic [OUT_CW-1:0]  out_cnt_in;
   logic [OUT_CW-1:0]  out_base;
   logic [1:0]         n_push;
   rsp_type            res0;
   rsp_type            res1;
   req_type            in_req;
   req_type            head_req;
   req_type            nxt_req;
   logic               req_fire;
   logic               rsp_fire;
   logic               op_known;
   logic               fifo_full;
   logic               fifo_push;
   logic               fifo_pop;
   logic               busy;
   logic               poll_now;
   logic               frame_done;

   assign in_req = '{op: req_op, address: req_address, length: req_length,
                     protect: req_protect, want_wait: req_want_wait};
   assign head_req = q_ff[0];

   generate
      if (QUEUE_DEPTH > 1) begin : g_next
         assign nxt_req = q_ff[1];
      end else begin : g_single
         assign nxt_req = q_ff[0];
      end
   endgenerate

   assign req_ready = out_cnt_ff <= OUT_CW'(OUT_DEPTH - 2);
   assign req_fire = req_valid && req_ready;
   assign rsp_valid = out_cnt_ff != '0;
   assign rsp_fire = rsp_valid && rsp_ready;

   assign op_known = req_op inside {[OP_ID:OP_PROTECT]};
   assign fifo_full = fifo_cnt_ff == CNT_W'(QUEUE_DEPTH);
   assign busy = fifo_cnt_ff != '0;
   assign frame_done = req_fire && req_func && busy;
   assign fifo_push = req_fire && !req_func && op_known && !fifo_full;
   assign poll_now = (phase_ff == PH_MAIN && waits(head_req)) ||
                     (phase_ff == PH_POLL && req_reply_one[0]);
   assign fifo_pop = frame_done && phase_ff != PH_PRELUDE && !poll_now;

   always_comb begin
      phase_in = phase_ff;
      if (fifo_push && !busy) begin
         phase_in = start_phase(req_op);
      end else if (frame_done) begin
         case (phase_ff)
            PH_PRELUDE: begin
               phase_in = PH_MAIN;
            end
            PH_MAIN, PH_POLL: begin
               if (poll_now) begin
                  phase_in = PH_POLL;
               end else if (fifo_cnt_ff > CNT_W'(1)) begin
                  phase_in = start_phase(nxt_req.op);
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_comb begin
      res0 = '0;
      res1 = '0;
      n_push = 2'd0;
      if (req_fire && !req_func && op_known) begin
         if (fifo_full) begin
            res0.kind = KIND_REJECT;
            res0.opcode = {4'b0000, req_op};
            res0.last = 1'b1;
            n_push = 2'd1;
         end else if (!busy) begin
            res0 = start_frame(in_req);
            n_push = 2'd1;
         end
      end else if (frame_done) begin
         n_push = 2'd1;
         if (phase_ff == PH_PRELUDE) begin
            res0 = main_frame(head_req);
            res0.last = 1'b1;
         end else if (poll_now) begin
            res0.kind = KIND_FRAME;
            res0.opcode = CMD_READ_STATUS;
            res0.rx_len = RX_STATUS;
            res0.last = 1'b1;
         end else begin
            res0.kind = KIND_DONE;
            res0.opcode = {4'b0000, head_req.op};
            if (phase_ff == PH_POLL || head_req.op == OP_STATUS) begin
               res0.done_one = req_reply_one;
            end else if (head_req.op == OP_ID) begin
               res0.done_one = req_reply_one;
               res0.done_two = req_reply_two;
               res0.done_three = req_reply_three;
            end
            if (fifo_cnt_ff > CNT_W'(1)) begin
               res1 = start_frame(nxt_req);
               n_push = 2'd2;
            end else begin
               res0.last = 1'b1;
            end
         end
      end
   end

   // Request queue: the head always sits in slot 0.
   always_comb begin
      q_in = q_ff;
      fifo_cnt_in = fifo_cnt_ff;
      if (fifo_pop) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            q_in[i] = q_ff[i + 1];
         end
         fifo_cnt_in = fifo_cnt_ff - CNT_W'(1);
      end else if (fifo_push) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (fifo_cnt_ff == CNT_W'(i)) begin
               q_in[i] = in_req;
            end
         end
         fifo_cnt_in = fifo_cnt_ff + CNT_W'(1);
      end
   end

   // Output queue: slot 0 drives the result ports.
   always_comb begin
      out_in = out_ff;
      out_base = out_cnt_ff;
      if (rsp_fire) begin
         for (int i = 0; i < OUT_DEPTH - 1; i++) begin
            out_in[i] = out_ff[i + 1];
         end
         out_base = out_cnt_ff - OUT_CW'(1);
      end
      for (int i = 0; i < OUT_DEPTH; i++) begin
         if (n_push != 2'd0 && out_base == OUT_CW'(i)) begin
            out_in[i] = res0;
         end
         if (n_push == 2'd2 && out_base + OUT_CW'(1) == OUT_CW'(i)) begin
            out_in[i] = res1;
         end
      end
      out_cnt_in = out_base + OUT_CW'(n_push);
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      out_ff <= out_in;
      if (reset) begin
         fifo_cnt_ff <= '0;
         phase_ff <= PH_IDLE;
         out_cnt_ff <= '0;
      end else begin
         fifo_cnt_ff <= fifo_cnt_in;
         phase_ff <= phase_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   assign rsp_kind = out_ff[0].kind;
   assign rsp_opcode = out_ff[0].opcode;
   assign rsp_frame_address = out_ff[0].frame_address;
   assign rsp_has_address = out_ff[0].has_address;
   assign rsp_extra_byte = out_ff[0].extra_byte;
   assign rsp_has_extra_byte = out_ff[0].has_extra_byte;
   assign rsp_tx_data_len = out_ff[0].tx_data_len;
   assign rsp_rx_len = out_ff[0].rx_len;
   assign rsp_done_one = out_ff[0].done_one;
   assign rsp_done_two = out_ff[0].done_two;
   assign rsp_done_three = out_ff[0].done_three;
   assign rsp_last = out_ff[0].last;

   // The phase is idle exactly when no request is queued.
   a_phase_matches_queue: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) == (fifo_cnt_ff == '0))
      else $error("phase and request count disagree");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_cnt_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("request queue overflow");

   a_out_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= OUT_CW'(OUT_DEPTH))
      else $error("result queue overflow");

   // A finished frame for a queued request always yields a result item.
   a_frame_answered: assert property (@(posedge clock) disable iff (reset)
      frame_done |=> out_cnt_ff != '0)
      else $error("finished frame produced no result");

   // A completion removes exactly one request from the queue.
   a_pop_once: assert property (@(posedge clock) disable iff (reset)
      fifo_pop |=> fifo_cnt_ff == $past(fifo_cnt_ff) - CNT_W'(1))
      else $error("completion did not retire one request");

endmodule

`default_nettype wire

/* tb/sv/spi_flash_command_sequencer_tb.sv */
// Self-checking testbench for the SPI flash command sequencer, with a predicting scoreboard.
`timescale 1ns / 1ps

module spi_flash_command_sequencer_tb;
   import sfcs_pkg::*;

   localparam int REQUEST_SLOTS = 8;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 12;

   class sequencer_scoreboard;
      req_type   queued_requests[$];
      phase_type phase;
      rsp_type   expected_results[$];
      int        errors;

      function new();
         phase = PH_IDLE;
         errors = 0;
      endfunction

      function rsp_type predict_main_frame(req_type r);
         rsp_type v;
         v = '0;
         v.kind = KIND_FRAME;
         v.last = 1'b1;
         case (r.op)
            OP_ID: begin
               v.opcode = CMD_READ_ID;
               v.has_address = 1'b1;
               v.rx_len = RX_ID;
            end
            OP_STATUS: begin
               v.opcode = CMD_READ_STATUS;
               v.rx_len = RX_STATUS;
            end
            OP_READ: begin
               v.opcode = CMD_READ;
               v.frame_address = r.address;
               v.has_address = 1'b1;
               v.rx_len = RX_READ_HDR + {1'b0, r.length};
            end
            OP_PROGRAM: begin
               v.opcode = CMD_PROGRAM;
               v.frame_address = r.address;
               v.has_address = 1'b1;
               v.tx_data_len = r.length[7:0];
            end
            OP_SECTOR, OP_BLK32, OP_BLK64: begin
               v.opcode = (r.op == OP_SECTOR) ? CMD_SECTOR_ERASE :
                          (r.op == OP_BLK32) ? CMD_BLK32_ERASE : CMD_BLK64_ERASE;
               v.frame_address = r.address;
               v.has_address = 1'b1;
            end
            OP_CHIP: begin
               v.opcode = CMD_CHIP_ERASE;
            end
            default: begin
               v.opcode = CMD_WRITE_STATUS;
               v.extra_byte = r.protect ? PROTECT_ALL : PROTECT_NONE;
               v.has_extra_byte = 1'b1;
            end
         endcase
         return v;
      endfunction

      // Opens the request at the head of the queue with its prelude or its main frame.
      function rsp_type predict_first_frame();
         rsp_type v;
         req_type r;
         r = queued_requests[0];
         v = '0;
         v.kind = KIND_FRAME;
         v.last = 1'b1;
         if (r.op >= OP_PROGRAM && r.op <= OP_CHIP) begin
            v.opcode = CMD_WRITE_ENABLE;
            phase = PH_PRELUDE;
         end else if (r.op == OP_PROTECT) begin
            v.opcode = CMD_EWSR;
            phase = PH_PRELUDE;
         end else begin
            v = predict_main_frame(r);
            phase = PH_MAIN;
         end
         return v;
      endfunction

      // Returns 0 when the block ignores the item.
      function bit note_item(logic func, req_type r, logic [7:0] b1, logic [7:0] b2,
                             logic [7:0] b3);
         rsp_type v;
         req_type head;
         bit polls;
         v = '0;
         if (!func) begin
            if (r.op > OP_PROTECT) return 1'b0;
            if (queued_requests.size() >= REQUEST_SLOTS) begin
               v.kind = KIND_REJECT;
               v.opcode = {4'h0, r.op};
               v.last = 1'b1;
               expected_results.push_back(v);
               return 1'b1;
            end
            queued_requests.push_back(r);
            if (phase == PH_IDLE) expected_results.push_back(predict_first_frame());
            return 1'b1;
         end
         if (phase == PH_IDLE) return 1'b0;
         head = queued_requests[0];
         if (phase == PH_PRELUDE) begin
            expected_results.push_back(predict_main_frame(head));
            phase = PH_MAIN;
            return 1'b1;
         end
         polls = (head.op >= OP_PROGRAM && head.op <= OP_BLK64) ? head.want_wait :
                 (head.op == OP_CHIP);
         if ((phase == PH_MAIN && polls) || (phase == PH_POLL && b1[0])) begin
            v.kind = KIND_FRAME;
            v.opcode = CMD_READ_STATUS;
            v.rx_len = RX_STATUS;
            v.last = 1'b1;
            phase = PH_POLL;
            expected_results.push_back(v);
            return 1'b1;
         end
         v.kind = KIND_DONE;
         v.opcode = {4'h0, head.op};
         if (phase == PH_POLL || head.op == OP_STATUS) begin
            v.done_one = b1;
         end else if (head.op == OP_ID) begin
            v.done_one = b1;
            v.done_two = b2;
            v.done_three = b3;
         end
         void'(queued_requests.pop_front());
         phase = PH_IDLE;
         v.last = (queued_requests.size() == 0);
         expected_results.push_back(v);
         if (queued_requests.size() != 0) expected_results.push_back(predict_first_frame());
         return 1'b1;
      endfunction

      function void report(string field, longint unsigned want, longint unsigned got);
         errors++;
         $display("%0t: rsp_%s expected %0h actual %0h", $time, field, want, got);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result item kind %0h opcode %0h, none expected",
                     $time, got.kind, got.opcode);
            return;
         end
         e = expected_results.pop_front();
         if (got.kind !== e.kind) report("kind", e.kind, got.kind);
         if (got.opcode !== e.opcode) report("opcode", e.opcode, got.opcode);
         if (got.frame_address !== e.frame_address) begin
            report("frame_address", e.frame_address, got.frame_address);
         end
         if (got.has_address !== e.has_address) begin
            report("has_address", e.has_address, got.has_address);
         end
         if (got.extra_byte !== e.extra_byte) report("extra_byte", e.extra_byte, got.extra_byte);
         if (got.has_extra_byte !== e.has_extra_byte) begin
            report("has_extra_byte", e.has_extra_byte, got.has_extra_byte);
         end
         if (got.tx_data_len !== e.tx_data_len) begin
            report("tx_data_len", e.tx_data_len, got.tx_data_len);
         end
         if (got.rx_len !== e.rx_len) report("rx_len", e.rx_len, got.rx_len);
         if (got.done_one !== e.done_one) report("done_one", e.done_one, got.done_one);
         if (got.done_two !== e.done_two) report("done_two", e.done_two, got.done_two);
         if (got.done_three !== e.done_three) report("done_three", e.done_three, got.done_three);
         if (got.last !== e.last) report("last", e.last, got.last);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = 1'b0;
   logic [3:0]  req_op = '0;
   logic [23:0] req_address = '0;
   logic [15:0] req_length = '0;
   logic        req_protect = 1'b0;
   logic        req_want_wait = 1'b0;
   logic [7:0]  req_reply_one = '0;
   logic [7:0]  req_reply_two = '0;
   logic [7:0]  req_reply_three = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_opcode;
   logic [23:0] rsp_frame_address;
   logic        rsp_has_address;
   logic [7:0]  rsp_extra_byte;
   logic        rsp_has_extra_byte;
   logic [7:0]  rsp_tx_data_len;
   logic [16:0] rsp_rx_len;
   logic [7:0]  rsp_done_one;
   logic [7:0]  rsp_done_two;
   logic [7:0]  rsp_done_three;
   logic        rsp_last;

   sequencer_scoreboard board = new();
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   int  counted_items = 0;
   int  hold_count = 0;
   bit  hold_armed = 1'b0;
   bit  filling = 1'b0;

   spi_flash_command_sequencer #(
      .QUEUE_DEPTH(REQUEST_SLOTS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_op(req_op),
      .req_address(req_address),
      .req_length(req_length),
      .req_protect(req_protect),
      .req_want_wait(req_want_wait),
      .req_reply_one(req_reply_one),
      .req_reply_two(req_reply_two),
      .req_reply_three(req_reply_three),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_opcode(rsp_opcode),
      .rsp_frame_address(rsp_frame_address),
      .rsp_has_address(rsp_has_address),
      .rsp_extra_byte(rsp_extra_byte),
      .rsp_has_extra_byte(rsp_has_extra_byte),
      .rsp_tx_data_len(rsp_tx_data_len),
      .rsp_rx_len(rsp_rx_len),
      .rsp_done_one(rsp_done_one),
      .rsp_done_two(rsp_done_two),
      .rsp_done_three(rsp_done_three),
      .rsp_last(rsp_last)
   );

   always #2 clock = ~clock;

   // The consumer stalls at random, and once holds off for a long stretch to back up the block.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_armed && hold_count < HOLD_CYCLES) begin
         rsp_ready <= 1'b0;
         hold_count <= hold_count + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_result(rsp_type'{rsp_kind, rsp_opcode, rsp_frame_address, rsp_has_address,
                                      rsp_extra_byte, rsp_has_extra_byte, rsp_tx_data_len,
                                      rsp_rx_len, rsp_done_one, rsp_done_two, rsp_done_three,
                                      rsp_last});
      end
   end

   task automatic send(input logic func, input req_type r, input logic [7:0] b1,
                       input logic [7:0] b2, input logic [7:0] b3);
      req_valid <= 1'b1;
      req_func <= func;
      req_op <= r.op;
      req_address <= r.address;
      req_length <= r.length;
      req_protect <= r.protect;
      req_want_wait <= r.want_wait;
      req_reply_one <= b1;
      req_reply_two <= b2;
      req_reply_three <= b3;
      do @(posedge clock); while (!req_ready);
      if (board.note_item(func, r, b1, b2, b3)) counted_items++;
   endtask

   task automatic send_request(input logic [3:0] op, input logic [23:0] address,
                               input logic [15:0] length, input logic protect,
                               input logic want_wait);
      send(1'b0, req_type'{op, address, length, protect, want_wait}, 8'h00, 8'h00, 8'h00);
   endtask

   task automatic send_random();
      req_type    r;
      logic       func;
      logic [7:0] b1;
      int         dice;
      r.op = 4'($urandom_range(8));
      r.address = 24'($urandom);
      case ($urandom_range(9))
         0: r.length = 16'h0000;
         1: r.length = 16'hFFFF;
         2: r.length = 16'($urandom_range(256, 255));
         default: r.length = 16'($urandom);
      endcase
      r.protect = 1'($urandom);
      r.want_wait = 1'($urandom);
      b1 = 8'($urandom);
      if ($urandom_range(99) < 4) filling = !filling;
      dice = $urandom_range(99);
      if (dice < 3) begin
         func = 1'b0;
         r.op = 4'($urandom_range(15, 9));
      end else if (board.phase == PH_IDLE) begin
         func = (dice < 6);
      end else if (filling) begin
         func = (dice >= 85);
      end else begin
         func = (dice >= 35);
      end
      if (func && board.phase == PH_POLL) b1[0] = ($urandom_range(99) < 35);
      send(func, r, b1, 8'($urandom), 8'($urandom));
   endtask

   task automatic run_items(input int count, input int idle, input int stall);
      int target;
      target = counted_items + count;
      send_idle_pct = idle;
      stall_pct = stall;
      while (counted_items < target) begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         send_random();
      end
   endtask

   initial begin
      logic [7:0] finish_replies[16];
      int settle;
      // Reply byte of each finished frame while the directed queue drains; the chip erase
      // sees one busy status before it completes.
      finish_replies = '{8'hFF, 8'h81, 8'h00, 8'h00, 8'h00, 8'hFE, 8'h00, 8'h00,
                         8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h7E, 8'h00, 8'h00};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A frame finished while idle and an unknown operation are both ignored.
      send(1'b1, '0, 8'h01, 8'h02, 8'h03);
      send_request(4'hF, 24'hFFFFFF, 16'hFFFF, 1'b1, 1'b1);
      send_request(OP_ID, 24'h000000, 16'h0000, 1'b0, 1'b0);
      send_request(OP_STATUS, 24'h000000, 16'h0000, 1'b0, 1'b0);
      send_request(OP_READ, 24'hFFFFFF, 16'hFFFF, 1'b0, 1'b0);
      send_request(OP_PROGRAM, 24'h000000, 16'h01FF, 1'b1, 1'b1);
      send_request(OP_SECTOR, 24'h123456, 16'h0000, 1'b0, 1'b0);
      send_request(OP_BLK32, 24'hABCDEF, 16'h00FF, 1'b1, 1'b0);
      send_request(OP_CHIP, 24'h000000, 16'h0000, 1'b0, 1'b0);
      send_request(OP_PROTECT, 24'h000000, 16'h0000, 1'b1, 1'b0);
      // The queue is full now, so this request is rejected.
      send_request(OP_BLK64, 24'h800000, 16'h0100, 1'b0, 1'b1);
      foreach (finish_replies[k]) send(1'b1, '0, finish_replies[k], 8'h5A, 8'hC3);

      run_items(300, 0, 0);
      run_items(300, 58, 0);
      hold_armed <= 1'b1;
      run_items(80, 0, 0);
      hold_armed <= 1'b0;
      run_items(300, 0, 58);
      run_items(300, 22, 22);

      // Finish every queued request so the run ends with the block idle.
      stall_pct = 0;
      while (board.phase != PH_IDLE) send(1'b1, '0, 8'h00, 8'h00, 8'h00);
      req_valid <= 1'b0;
      while (board.expected_results.size() != 0) @(posedge clock);
      for (settle = 0; settle < SETTLE_CYCLES; settle++) @(posedge clock);

      if (board.errors == 0 && board.expected_results.size() == 0) begin
         $display("** spi_flash_command_sequencer: PASSED **");
      end else begin
         $display("** spi_flash_command_sequencer: FAILED **");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("%0t: timeout with %0d result items outstanding", $time,
               board.expected_results.size());
      $display("** spi_flash_command_sequencer: FAILED **");
      $finish;
   end

endmodule
